[rtl/hsv2rgb_pkg.sv]
package hsv2rgb_pkg;

	localparam logic [14:0] HUE_CIRCLE  = 15'd23040;
	localparam logic [11:0] HUE_SECTOR  = 12'd3840;
	localparam logic [14:0] SECTOR_W    = 15'd3840;
	localparam logic [7:0]  FRAC_ONE    = 8'd255;
	// floor(2^24 / 15), estimate is low by at most one
	localparam logic [20:0] DIV15_RECIP = 21'd1118481;

	// named after the channel at full value and the channel on the ramp
	typedef enum logic [2:0] {
		SEC_RED_GREEN  = 3'd0,
		SEC_GREEN_RED  = 3'd1,
		SEC_GREEN_BLUE = 3'd2,
		SEC_BLUE_GREEN = 3'd3,
		SEC_BLUE_RED   = 3'd4,
		SEC_RED_BLUE   = 3'd5
	} sector_t;

	typedef struct packed {
		sector_t     sector;
		logic [11:0] k;
		logic [15:0] vs;
		logic [15:0] d;
		logic [7:0]  v;
	} front_t;

	typedef struct packed {
		sector_t     sector;
		logic [15:0] t;
		logic [7:0]  r0;
		logic [7:0]  zero;
		logic [7:0]  v;
	} div_t;

	// x / 255 via x * 257 / 65536, low by at most one for x <= 65025
	function automatic logic [7:0] div255_est(input logic [15:0] x);
		logic [23:0] m;
		m = {x, 8'b0} + 24'(x);
		return m[23:16];
	endfunction

	function automatic logic [7:0] div255_fix(input logic [15:0] x, input logic [7:0] q0);
		logic [15:0] prod;
		logic [15:0] r;
		prod = {q0, 8'b0} - 16'(q0);
		r = x - prod;
		return (r >= 16'(FRAC_ONE)) ? q0 + 8'd1 : q0;
	endfunction

	function automatic logic [15:0] div15_est(input logic [19:0] p);
		logic [40:0] m;
		m = 41'(p) * 41'(DIV15_RECIP);
		return m[39:24];
	endfunction

	function automatic logic [15:0] div15_fix(input logic [19:0] p, input logic [15:0] q0);
		logic [19:0] prod;
		logic [19:0] r;
		prod = {q0, 4'b0} - 20'(q0);
		r = p - prod;
		return (r >= 20'd15) ? q0 + 16'd1 : q0;
	endfunction

endpackage

[rtl/hsv_to_rgb_converter_core.sv]
// channel  direction  fields                         handshake
// pixel    in         hue, saturation, brightness    pixel_valid / pixel_stall
// rgb      out        red, green, blue               rgb_valid / rgb_stall
//
// one pixel per clock unless rgb_stall holds the pipeline
// the pipeline has seven register stages (products, two reciprocal
// divides with correction steps, sector placement in the output register)
// reset clears only the stage valid bits, data registers are not reset
// a stage holds only while it is full and the stage after it cannot take,
// so empty stages keep filling while rgb_stall is high
module hsv_to_rgb_converter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pixel_valid,
	output logic        pixel_stall,
	input  logic [14:0] hue,
	input  logic [7:0]  saturation,
	input  logic [7:0]  brightness,
	output logic        rgb_valid,
	input  logic        rgb_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue
);
	import hsv2rgb_pkg::*;

	localparam int Stages = 7;

	logic [Stages-1:0] vld_q;
	logic [Stages-1:0] adv;
	front_t            front;
	div_t              quot;

	logic [7:0] ramp;
	logic [7:0] r_nxt;
	logic [7:0] g_nxt;
	logic [7:0] b_nxt;

	always_comb begin
		adv[Stages-1] = !vld_q[Stages-1] || !rgb_stall;
		for (int i = Stages - 2; i >= 0; i--) begin
			adv[i] = !vld_q[i] || adv[i+1];
		end
	end

	assign pixel_stall = !adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= pixel_valid;
			end
			for (int i = 1; i < Stages; i++) begin
				if (adv[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	hsv2rgb_front u_front (
		.clk        (clk),
		.adv        (adv[1:0]),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.front      (front)
	);

	hsv2rgb_div u_div (
		.clk   (clk),
		.adv   (adv[5:2]),
		.front (front),
		.quot  (quot)
	);

	assign ramp = div255_fix(quot.t, quot.r0);

	always_comb begin
		case (quot.sector)
			SEC_RED_GREEN: begin
				r_nxt = quot.v;
				g_nxt = ramp;
				b_nxt = quot.zero;
			end
			SEC_GREEN_RED: begin
				r_nxt = ramp;
				g_nxt = quot.v;
				b_nxt = quot.zero;
			end
			SEC_GREEN_BLUE: begin
				r_nxt = quot.zero;
				g_nxt = quot.v;
				b_nxt = ramp;
			end
			SEC_BLUE_GREEN: begin
				r_nxt = quot.zero;
				g_nxt = ramp;
				b_nxt = quot.v;
			end
			SEC_BLUE_RED: begin
				r_nxt = ramp;
				g_nxt = quot.zero;
				b_nxt = quot.v;
			end
			SEC_RED_BLUE: begin
				r_nxt = quot.v;
				g_nxt = quot.zero;
				b_nxt = ramp;
			end
			default: begin
				r_nxt = quot.v;
				g_nxt = quot.zero;
				b_nxt = ramp;
			end
		endcase
	end

	logic [7:0] red_s7;
	logic [7:0] green_s7;
	logic [7:0] blue_s7;

	always_ff @(posedge clk) begin
		if (adv[Stages-1]) begin
			red_s7   <= r_nxt;
			green_s7 <= g_nxt;
			blue_s7  <= b_nxt;
		end
	end

	assign rgb_valid = vld_q[Stages-1];
	assign red       = red_s7;
	assign green     = green_s7;
	assign blue      = blue_s7;

endmodule

[rtl/hsv2rgb_front.sv]
module hsv2rgb_front (
	input  logic                 clk,
	input  logic [1:0]           adv,
	input  logic [14:0]          hue,
	input  logic [7:0]           saturation,
	input  logic [7:0]           brightness,
	output hsv2rgb_pkg::front_t  front
);
	import hsv2rgb_pkg::*;

	logic [14:0] hue_s1;
	logic [15:0] vs_s1;
	logic [15:0] d_s1;
	logic [7:0]  v_s1;
	front_t      front_s2;

	sector_t     sec;
	logic [14:0] base;
	logic [11:0] pos;
	logic [11:0] k;

	// stage 1: wrap hue once, chroma products
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			hue_s1 <= (hue >= HUE_CIRCLE) ? hue - HUE_CIRCLE : hue;
			vs_s1  <= 16'(saturation) * 16'(brightness);
			d_s1   <= 16'(FRAC_ONE - saturation) * 16'(brightness);
			v_s1   <= brightness;
		end
	end

	always_comb begin
		if (hue_s1 >= 15'(5 * SECTOR_W)) begin
			sec = SEC_RED_BLUE;
			base = 15'(5 * SECTOR_W);
		end else if (hue_s1 >= 15'(4 * SECTOR_W)) begin
			sec = SEC_BLUE_RED;
			base = 15'(4 * SECTOR_W);
		end else if (hue_s1 >= 15'(3 * SECTOR_W)) begin
			sec = SEC_BLUE_GREEN;
			base = 15'(3 * SECTOR_W);
		end else if (hue_s1 >= 15'(2 * SECTOR_W)) begin
			sec = SEC_GREEN_BLUE;
			base = 15'(2 * SECTOR_W);
		end else if (hue_s1 >= SECTOR_W) begin
			sec = SEC_GREEN_RED;
			base = SECTOR_W;
		end else begin
			sec = SEC_RED_GREEN;
			base = 15'd0;
		end
		pos = 12'(hue_s1 - base);
		// ramp falls across odd sectors
		k = sec[0] ? HUE_SECTOR - pos : pos;
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			front_s2.sector <= sec;
			front_s2.k      <= k;
			front_s2.vs     <= vs_s1;
			front_s2.d      <= d_s1;
			front_s2.v      <= v_s1;
		end
	end

	assign front = front_s2;

endmodule

[rtl/hsv2rgb_div.sv]
module hsv2rgb_div (
	input  logic                 clk,
	input  logic [3:0]           adv,
	input  hsv2rgb_pkg::front_t  front,
	output hsv2rgb_pkg::div_t    quot
);
	import hsv2rgb_pkg::*;

	logic [27:0] prod;

	logic [19:0] p_s3;
	logic [7:0]  z0_s3;
	logic [15:0] d_s3;
	logic [7:0]  v_s3;
	sector_t     sector_s3;

	logic [19:0] p_s4;
	logic [15:0] q0_s4;
	logic [7:0]  zero_s4;
	logic [15:0] d_s4;
	logic [7:0]  v_s4;
	sector_t     sector_s4;

	logic [16:0] t_sum;
	logic [15:0] t_s5;
	logic [7:0]  zero_s5;
	logic [7:0]  v_s5;
	sector_t     sector_s5;

	div_t        quot_s6;

	assign prod = 28'(front.vs) * 28'(front.k);

	// stage 3: ramp product over 256, first guess of the floor level
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			p_s3      <= prod[27:8];
			z0_s3     <= div255_est(front.d);
			d_s3      <= front.d;
			v_s3      <= front.v;
			sector_s3 <= front.sector;
		end
	end

	// stage 4: divide by 15 estimate, floor level corrected
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			p_s4      <= p_s3;
			q0_s4     <= div15_est(p_s3);
			zero_s4   <= div255_fix(d_s3, z0_s3);
			d_s4      <= d_s3;
			v_s4      <= v_s3;
			sector_s4 <= sector_s3;
		end
	end

	// t = floor(ramp numerator / 3840), never above 255 * v
	assign t_sum = 17'(d_s4) + 17'(div15_fix(p_s4, q0_s4));

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			t_s5      <= t_sum[15:0];
			zero_s5   <= zero_s4;
			v_s5      <= v_s4;
			sector_s5 <= sector_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			quot_s6.t      <= t_s5;
			quot_s6.r0     <= div255_est(t_s5);
			quot_s6.zero   <= zero_s5;
			quot_s6.v      <= v_s5;
			quot_s6.sector <= sector_s5;
		end
	end

	assign quot = quot_s6;

endmodule
